[sv/stp_pkg.sv]
// Shared types and constants for the sparse triplet text parser.
// Holds character codes, result kinds, error codes and the result record.
// No dependencies.
package stp_pkg;

    // Character codes of the body text
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Configuration register indexes
    localparam int unsigned CFG_COUNT = 3;
    localparam int unsigned CFG_INDEX_WIDTH = $clog2(CFG_COUNT);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROW_COUNT        = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COLUMN_COUNT     = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPECTED_ENTRIES = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_TRIPLET = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_BAD_BYTE   = 4'd1;
    localparam logic [3:0] ERR_OVERFLOW   = 4'd2;
    localparam logic [3:0] ERR_RANGE      = 4'd3;
    localparam logic [3:0] ERR_ZERO       = 4'd4;
    localparam logic [3:0] ERR_INCOMPLETE = 4'd5;
    localparam logic [3:0] ERR_COUNT      = 4'd6;
    localparam logic [3:0] ERR_DUPLICATE  = 4'd7;
    localparam logic [3:0] ERR_UNSORTED   = 4'd8;

    // Output queue: room for one waiting result plus the two an end item can give
    localparam int unsigned QUEUE_DEPTH = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] row_index;
        logic [31:0] column_index;
        logic [63:0] entry_value;
        logic [3:0]  error_code;
        logic [63:0] entries_seen;
        logic [63:0] duplicates_seen;
        logic        sorted_so_far;
        logic        last_result;
    } result_t;

endpackage

[sv/sparse_triplet_text_parser.sv]
// Top level of the sparse triplet text parser: byte parser, triplet checks
// and a three-entry output queue of result transactions.
// Depends on stp_pkg.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_stall    | text_byte, stream_end
//  output   | out_valid / out_stall  | kind, row_index, column_index, entry_value,
//           |                        | error_code, entries_seen, duplicates_seen,
//           |                        | sorted_so_far, last_result
//  config   | cfg_write              | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; its result, if any, is queued at
// the same edge and shown on the output once the results ahead of it are taken.
// The parser state is updated from the state registers and the accepted byte;
// the 68-bit multiply-by-ten add sets the longest path.
// in_stall rises while two or more results wait in the queue, so an end item
// with two results always finds room.
// Reset clears parser state and queue; rows and columns reset to 1, entries to 0.
module sparse_triplet_text_parser
    import stp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [63:0]                cfg_data,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 text_byte,
    input  logic                       stream_end,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 kind,
    output logic [31:0]                row_index,
    output logic [31:0]                column_index,
    output logic [63:0]                entry_value,
    output logic [3:0]                 error_code,
    output logic [63:0]                entries_seen,
    output logic [63:0]                duplicates_seen,
    output logic                       sorted_so_far,
    output logic                       last_result
);

    localparam int unsigned PTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(QUEUE_DEPTH - 1);

    // Configuration registers
    logic [31:0] row_count_reg;
    logic [31:0] column_count_reg;
    logic [63:0] expected_entries_reg;

    // Parser state
    logic [63:0] acc_reg, acc_next;
    logic        inside_reg, inside_next;
    logic [1:0]  field_pos_reg, field_pos_next;
    logic [63:0] first_reg, first_next;
    logic [63:0] second_reg, second_next;
    logic [31:0] prev_row_reg, prev_row_next;
    logic [31:0] prev_col_reg, prev_col_next;
    logic [63:0] entry_cnt_reg, entry_cnt_next;
    logic [63:0] dup_cnt_reg, dup_cnt_next;
    logic        order_reg, order_next;
    logic        halted_reg, halted_next;

    // Output queue
    result_t                queue_reg [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_WIDTH-1:0]   count_reg;

    // Per-transaction working signals
    logic        accept;
    logic        pop;
    logic        is_digit;
    logic        is_space;
    logic [67:0] acc_times_ten;
    logic        overflow;
    logic        closing;
    logic        range_bad;
    logic        value_zero;
    logic        triplet_done;
    logic        triplet_ok;
    logic        close_fail;
    logic [31:0] trip_row;
    logic [31:0] trip_col;
    logic [1:0]  pos_after;
    logic [3:0]  end_code;
    logic        push_a, push_b;
    result_t     res_a, res_b;

    function automatic logic [PTR_WIDTH-1:0] ptr_inc(input logic [PTR_WIDTH-1:0] p);
        logic [PTR_WIDTH-1:0] r;
        r = (p == PTR_LAST) ? '0 : p + 1'b1;
        return r;
    endfunction

    function automatic result_t make_result(
        input logic [1:0]  k,
        input logic [31:0] r,
        input logic [31:0] c,
        input logic [63:0] v,
        input logic [3:0]  e,
        input logic [63:0] ent,
        input logic [63:0] dup,
        input logic        ord,
        input logic        last
    );
        result_t res;
        res.kind            = k;
        res.row_index       = r;
        res.column_index    = c;
        res.entry_value     = v;
        res.error_code      = e;
        res.entries_seen    = ent;
        res.duplicates_seen = dup;
        res.sorted_so_far   = ord;
        res.last_result     = last;
        return res;
    endfunction

    // Handshakes
    assign in_stall  = (count_reg >= CNT_WIDTH'(QUEUE_DEPTH - 1));
    assign accept    = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;

    // Classify the byte and build the next accumulator value
    assign is_digit      = text_byte inside {[CH_ZERO:CH_NINE]};
    assign is_space      = text_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    assign acc_times_ten = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                         + {64'd0, 4'(text_byte - CH_ZERO)};
    assign overflow      = |acc_times_ten[67:64];

    // Triplet checks on the number being closed
    assign closing      = inside_reg && (stream_end || is_space);
    assign triplet_done = closing && (field_pos_reg[1] == 1'b1);
    assign range_bad    = (first_reg == 64'd0) || (first_reg > {32'd0, row_count_reg})
                       || (second_reg == 64'd0) || (second_reg > {32'd0, column_count_reg});
    assign value_zero   = (acc_reg == 64'd0);
    assign close_fail   = triplet_done && (range_bad || value_zero);
    assign triplet_ok   = triplet_done && !range_bad && !value_zero;
    assign trip_row     = first_reg[31:0];
    assign trip_col     = second_reg[31:0];

    always_comb
    begin
        case (field_pos_reg)
            2'd0:    pos_after = closing ? 2'd1 : 2'd0;
            2'd1:    pos_after = closing ? 2'd2 : 2'd1;
            default: pos_after = closing ? 2'd0 : field_pos_reg;
        endcase
    end

    // Update counters and order flag for a good triplet
    always_comb
    begin
        entry_cnt_next = entry_cnt_reg;
        dup_cnt_next   = dup_cnt_reg;
        order_next     = order_reg;
        prev_row_next  = prev_row_reg;
        prev_col_next  = prev_col_reg;
        if (triplet_ok)
        begin
            if (entry_cnt_reg != 64'd0)
            begin
                if ((trip_col < prev_col_reg)
                    || ((trip_col == prev_col_reg) && (trip_row < prev_row_reg)))
                    order_next = 1'b0;
                if ((trip_col == prev_col_reg) && (trip_row == prev_row_reg))
                    dup_cnt_next = dup_cnt_reg + 64'd1;
            end
            prev_row_next  = trip_row;
            prev_col_next  = trip_col;
            entry_cnt_next = entry_cnt_reg + 64'd1;
        end
    end

    // Pick the end-of-stream outcome by precedence
    always_comb
    begin
        if (pos_after != 2'd0)
            end_code = ERR_INCOMPLETE;
        else if (entry_cnt_next != expected_entries_reg)
            end_code = ERR_COUNT;
        else if (dup_cnt_next != 64'd0)
            end_code = ERR_DUPLICATE;
        else if (!order_next)
            end_code = ERR_UNSORTED;
        else
            end_code = ERR_NONE;
    end

    // Decide the results of this transaction and the next parser state
    always_comb
    begin
        acc_next       = acc_reg;
        inside_next    = inside_reg;
        field_pos_next = field_pos_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        halted_next    = halted_reg;
        push_a         = 1'b0;
        push_b         = 1'b0;
        res_a = make_result(KIND_ERROR, 32'd0, 32'd0, 64'd0, ERR_BAD_BYTE,
                            entry_cnt_reg, dup_cnt_reg, order_reg, 1'b1);
        res_b = make_result(end_code == ERR_NONE ? KIND_SUMMARY : KIND_ERROR,
                            32'd0, 32'd0, 64'd0, end_code,
                            entry_cnt_next, dup_cnt_next, order_next, 1'b1);

        if (accept && !halted_reg)
        begin
            if (stream_end || is_space)
            begin
                // Close any pending number
                if (closing)
                begin
                    acc_next       = 64'd0;
                    inside_next    = 1'b0;
                    field_pos_next = pos_after;
                    if (field_pos_reg == 2'd0)
                        first_next = acc_reg;
                    if (field_pos_reg == 2'd1)
                        second_next = acc_reg;
                end
                if (close_fail)
                begin
                    push_a      = 1'b1;
                    halted_next = 1'b1;
                    res_a.error_code = range_bad ? ERR_RANGE : ERR_ZERO;
                end
                else if (triplet_ok)
                begin
                    push_a = 1'b1;
                    res_a  = make_result(KIND_TRIPLET, trip_row, trip_col, acc_reg, ERR_NONE,
                                         entry_cnt_next, dup_cnt_next, order_next,
                                         !stream_end);
                end
                // End item: summary or error after any triplet
                if (stream_end && !close_fail)
                begin
                    halted_next = 1'b1;
                    if (triplet_ok)
                        push_b = 1'b1;
                    else
                    begin
                        push_a = 1'b1;
                        res_a  = res_b;
                    end
                end
            end
            else if (is_digit)
            begin
                if (overflow)
                begin
                    push_a      = 1'b1;
                    halted_next = 1'b1;
                    res_a.error_code = ERR_OVERFLOW;
                end
                else
                begin
                    acc_next    = acc_times_ten[63:0];
                    inside_next = 1'b1;
                end
            end
            else
            begin
                // Any other byte
                push_a      = 1'b1;
                halted_next = 1'b1;
            end
        end
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg        <= 32'd1;
            column_count_reg     <= 32'd1;
            expected_entries_reg <= 64'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ROW_COUNT:        row_count_reg        <= cfg_data[31:0];
                CFG_COLUMN_COUNT:     column_count_reg     <= cfg_data[31:0];
                CFG_EXPECTED_ENTRIES: expected_entries_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Advance the parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 64'd0;
            inside_reg    <= 1'b0;
            field_pos_reg <= 2'd0;
            first_reg     <= 64'd0;
            second_reg    <= 64'd0;
            prev_row_reg  <= 32'd0;
            prev_col_reg  <= 32'd0;
            entry_cnt_reg <= 64'd0;
            dup_cnt_reg   <= 64'd0;
            order_reg     <= 1'b1;
            halted_reg    <= 1'b0;
        end
        else if (accept && !halted_reg)
        begin
            acc_reg       <= acc_next;
            inside_reg    <= inside_next;
            field_pos_reg <= field_pos_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            prev_row_reg  <= prev_row_next;
            prev_col_reg  <= prev_col_next;
            entry_cnt_reg <= entry_cnt_next;
            dup_cnt_reg   <= dup_cnt_next;
            order_reg     <= order_next;
            halted_reg    <= halted_next;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_a && push_b)
                wr_ptr_reg <= ptr_inc(ptr_inc(wr_ptr_reg));
            else if (push_a)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_reg + CNT_WIDTH'(push_a) + CNT_WIDTH'(push_b)
                       - CNT_WIDTH'(pop);
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (push_a)
            queue_reg[wr_ptr_reg] <= res_a;
        if (push_b)
            queue_reg[ptr_inc(wr_ptr_reg)] <= res_b;
    end

    // Drive the head of the queue
    assign kind            = queue_reg[rd_ptr_reg].kind;
    assign row_index       = queue_reg[rd_ptr_reg].row_index;
    assign column_index    = queue_reg[rd_ptr_reg].column_index;
    assign entry_value     = queue_reg[rd_ptr_reg].entry_value;
    assign error_code      = queue_reg[rd_ptr_reg].error_code;
    assign entries_seen    = queue_reg[rd_ptr_reg].entries_seen;
    assign duplicates_seen = queue_reg[rd_ptr_reg].duplicates_seen;
    assign sorted_so_far   = queue_reg[rd_ptr_reg].sorted_so_far;
    assign last_result     = queue_reg[rd_ptr_reg].last_result;

    // Checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_WIDTH'(QUEUE_DEPTH))
        else $error("output queue overfilled");

    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (count_reg < CNT_WIDTH'(QUEUE_DEPTH - 1)))
        else $error("transaction accepted without room for two results");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (!push_a && !push_b))
        else $error("result produced after halt");

    a_second_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        push_b |-> (push_a && stream_end && triplet_ok))
        else $error("second result outside an end transaction");

    a_order_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !order_reg |=> !order_reg)
        else $error("order flag recovered without reset");

endmodule

[tb/tb_sparse_triplet_text_parser.sv]
// Self-checking testbench for the sparse triplet text parser.
// Drives one coordinate-format body stream, mirrors the parser in a small class
// and checks every result transaction. Depends on stp_pkg and the parser top level.
`timescale 1ns / 100ps

import stp_pkg::*;

function automatic bit is_blank(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
endfunction

// Mirror of the parser: register copies, parse state and the queue of results still owed
class triplet_ledger;
    logic [31:0] row_limit;
    logic [31:0] column_limit;
    logic [63:0] declared_entries;

    logic [63:0] acc;
    bit          in_num;
    logic [1:0]  field_pos;
    logic [63:0] row_field;
    logic [63:0] column_field;
    logic [31:0] last_row;
    logic [31:0] last_column;
    logic [63:0] entry_count;
    logic [63:0] repeat_count;
    bit          ordered;
    bit          stopped;

    result_t     pending_results[$];
    int unsigned fail_count;

    function new();
        row_limit        = 32'd1;
        column_limit     = 32'd1;
        declared_entries = 64'd0;
        acc              = 64'd0;
        in_num           = 1'b0;
        field_pos        = 2'd0;
        row_field        = 64'd0;
        column_field     = 64'd0;
        last_row         = 32'd0;
        last_column      = 32'd0;
        entry_count      = 64'd0;
        repeat_count     = 64'd0;
        ordered          = 1'b1;
        stopped          = 1'b0;
        fail_count       = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [63:0] data);
        case (idx)
            CFG_ROW_COUNT:        row_limit = data[31:0];
            CFG_COLUMN_COUNT:     column_limit = data[31:0];
            CFG_EXPECTED_ENTRIES: declared_entries = data;
            default: ;
        endcase
    endfunction

    // Counters and order flag are taken as they stand at the moment of the call
    function void add_result(logic [1:0] k, logic [31:0] r, logic [31:0] c,
                             logic [63:0] v, logic [3:0] code);
        result_t res;
        res.kind            = k;
        res.row_index       = r;
        res.column_index    = c;
        res.entry_value     = v;
        res.error_code      = code;
        res.entries_seen    = entry_count;
        res.duplicates_seen = repeat_count;
        res.sorted_so_far   = ordered;
        res.last_result     = 1'b0;
        pending_results.push_back(res);
    endfunction

    function void halt_with(logic [3:0] code);
        add_result(KIND_ERROR, 32'd0, 32'd0, 64'd0, code);
        stopped = 1'b1;
    endfunction

    // Close the pending number; return 1 when it ends the stream with an error
    function bit close_field();
        logic [63:0] v;
        v      = acc;
        acc    = 64'd0;
        in_num = 1'b0;
        if (field_pos == 2'd0) begin
            row_field = v;
            field_pos = 2'd1;
            return 1'b0;
        end
        if (field_pos == 2'd1) begin
            column_field = v;
            field_pos    = 2'd2;
            return 1'b0;
        end
        field_pos = 2'd0;
        if (row_field == 64'd0 || row_field > {32'd0, row_limit} ||
            column_field == 64'd0 || column_field > {32'd0, column_limit}) begin
            halt_with(ERR_RANGE);
            return 1'b1;
        end
        if (v == 64'd0) begin
            halt_with(ERR_ZERO);
            return 1'b1;
        end
        if (entry_count != 64'd0) begin
            if (column_field[31:0] < last_column ||
                (column_field[31:0] == last_column && row_field[31:0] < last_row))
                ordered = 1'b0;
            if (column_field[31:0] == last_column && row_field[31:0] == last_row)
                repeat_count = repeat_count + 64'd1;
        end
        last_row    = row_field[31:0];
        last_column = column_field[31:0];
        entry_count = entry_count + 64'd1;
        add_result(KIND_TRIPLET, row_field[31:0], column_field[31:0], v, ERR_NONE);
        return 1'b0;
    endfunction

    // Note one accepted input transaction and queue the results it owes
    function void take_byte(logic [7:0] b, logic fin);
        int unsigned queued;
        bit          failed;
        logic [63:0] digit;
        if (stopped)
            return;
        queued = pending_results.size();
        failed = 1'b0;
        if (fin) begin
            if (in_num)
                failed = close_field();
            if (!failed) begin
                if (field_pos != 2'd0)
                    halt_with(ERR_INCOMPLETE);
                else if (entry_count != declared_entries)
                    halt_with(ERR_COUNT);
                else if (repeat_count != 64'd0)
                    halt_with(ERR_DUPLICATE);
                else if (!ordered)
                    halt_with(ERR_UNSORTED);
                else begin
                    add_result(KIND_SUMMARY, 32'd0, 32'd0, 64'd0, ERR_NONE);
                    stopped = 1'b1;
                end
            end
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            digit = {56'd0, b - CH_ZERO};
            if (acc > (64'hFFFF_FFFF_FFFF_FFFF - digit) / 64'd10)
                halt_with(ERR_OVERFLOW);
            else begin
                acc    = acc * 64'd10 + digit;
                in_num = 1'b1;
            end
        end else if (is_blank(b)) begin
            if (in_num)
                void'(close_field());
        end else
            halt_with(ERR_BAD_BYTE);
        // Flag the final result of this transaction
        if (pending_results.size() > queued)
            pending_results[pending_results.size() - 1].last_result = 1'b1;
    endfunction

    function bit field_differs(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Check one accepted result transaction against the oldest one owed
    function void match_result(result_t got);
        result_t want;
        bit      bad;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0h error %0h",
                     $time, got.kind, got.error_code);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        bad  = 1'b0;
        bad |= field_differs("kind", 64'(want.kind), 64'(got.kind));
        bad |= field_differs("row_index", 64'(want.row_index), 64'(got.row_index));
        bad |= field_differs("column_index", 64'(want.column_index),
                             64'(got.column_index));
        bad |= field_differs("entry_value", want.entry_value, got.entry_value);
        bad |= field_differs("error_code", 64'(want.error_code), 64'(got.error_code));
        bad |= field_differs("entries_seen", want.entries_seen, got.entries_seen);
        bad |= field_differs("duplicates_seen", want.duplicates_seen, got.duplicates_seen);
        bad |= field_differs("sorted_so_far", 64'(want.sorted_so_far),
                             64'(got.sorted_so_far));
        bad |= field_differs("last_result", 64'(want.last_result), 64'(got.last_result));
        if (bad)
            fail_count++;
    endfunction
endclass

module tb_sparse_triplet_text_parser;

    localparam int CYCLE_LIMIT = 200000;

    // How the stream ends; one case is drawn per run
    typedef enum int {
        FINISH_CLEAN, FINISH_UNSORTED, FINISH_DUPLICATE, FINISH_MISMATCH,
        FINISH_INCOMPLETE, FINISH_ZERO_VALUE, FINISH_RANGE, FINISH_OVERFLOW,
        FINISH_BAD_BYTE
    } finish_kind_e;

    typedef enum int {STYLE_ORDERED, STYLE_DISTINCT, STYLE_FREE} coord_style_e;

    typedef enum int {
        PACE_STEADY, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH
    } pace_e;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_ROW_COUNT;
    logic [63:0]                cfg_data = 64'd0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [7:0]                 text_byte = 8'd0;
    logic                       stream_end = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [1:0]                 kind;
    logic [31:0]                row_index;
    logic [31:0]                column_index;
    logic [63:0]                entry_value;
    logic [3:0]                 error_code;
    logic [63:0]                entries_seen;
    logic [63:0]                duplicates_seen;
    logic                       sorted_so_far;
    logic                       last_result;

    triplet_ledger ledger;
    finish_kind_e  finish_case;
    coord_style_e  order_style;
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            hold_left = 0;
    int            items_sent = 0;
    int            cycle_count = 0;

    sparse_triplet_text_parser dut (.*);

    always #5 clk = ~clk;

    // Give up on a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Take result transactions; hold off for a long stretch on request, else stall at random
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                ledger.match_result({kind, row_index, column_index, entry_value, error_code,
                                     entries_seen, duplicates_seen, sorted_so_far,
                                     last_result});
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Offer one input transaction and wait until it is taken
    task automatic send_item(logic [7:0] b, logic fin);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        text_byte  <= b;
        stream_end <= fin;
        do
            @(posedge clk);
        while (in_stall);
        ledger.take_byte(b, fin);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_number(logic [63:0] v);
        logic [7:0]  digits [0:19];
        logic [63:0] x;
        int          n;
        x = v;
        n = 0;
        do begin
            digits[n] = CH_ZERO + 8'(x % 64'd10);
            x = x / 64'd10;
            n++;
        end while (x != 64'd0);
        // Pad with leading zeros now and then
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2)) send_item(CH_ZERO, 1'b0);
        for (int i = n - 1; i >= 0; i--)
            send_item(digits[i], 1'b0);
    endtask

    task automatic send_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       send_item(CH_SPACE, 1'b0);
                1:       send_item(CH_TAB, 1'b0);
                2:       send_item(CH_CR, 1'b0);
                default: send_item(CH_LF, 1'b0);
            endcase
        end
    endtask

    task automatic send_triplet(logic [63:0] r, logic [63:0] c, logic [63:0] v, bit trail);
        send_number(r);
        send_gap();
        send_number(c);
        send_gap();
        send_number(v);
        if (trail)
            send_gap();
    endtask

    // Wait until every owed result has come, then let the pipeline settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (ledger.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all three registers; junk in the unused upper half of the 32-bit ones
    task automatic write_settings(logic [31:0] rows, logic [31:0] columns,
                                  logic [63:0] entries);
        cfg_write <= 1'b1;
        cfg_index <= CFG_ROW_COUNT;
        cfg_data  <= {$urandom, rows};
        @(posedge clk);
        ledger.set_register(CFG_ROW_COUNT, cfg_data);
        cfg_index <= CFG_COLUMN_COUNT;
        cfg_data  <= {$urandom, columns};
        @(posedge clk);
        ledger.set_register(CFG_COLUMN_COUNT, cfg_data);
        cfg_index <= CFG_EXPECTED_ENTRIES;
        cfg_data  <= entries;
        @(posedge clk);
        ledger.set_register(CFG_EXPECTED_ENTRIES, cfg_data);
        cfg_write <= 1'b0;
    endtask

    // Mostly small indexes, sometimes anywhere in range
    function automatic logic [31:0] any_index(logic [31:0] bound);
        if (bound <= 32'd64 || $urandom_range(0, 3) != 0)
            return $urandom_range(1, (bound < 32'd64) ? bound : 32'd64);
        return $urandom_range(1, bound);
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0:             return 64'hFFFF_FFFF_FFFF_FFFF;
            1, 2, 3, 4, 5: return 64'($urandom_range(1, 999));
            default: begin
                v = {$urandom, $urandom};
                return (v == 64'd0) ? 64'd1 : v;
            end
        endcase
    endfunction

    // Choose the next coordinate inside the current bounds, shaped by the run's style
    function automatic void pick_coordinate(output logic [31:0] r, output logic [31:0] c);
        logic [31:0] pr;
        logic [31:0] pc;
        logic [31:0] rc;
        logic [31:0] cc;
        bit          fresh;
        pr    = ledger.last_row;
        pc    = ledger.last_column;
        rc    = ledger.row_limit;
        cc    = ledger.column_limit;
        fresh = (ledger.entry_count == 64'd0);
        case (order_style)
            STYLE_ORDERED: begin
                if (fresh) begin
                    r = any_index(rc);
                    c = 32'd1;
                end else if (pr < rc && $urandom_range(0, 2) != 0) begin
                    r = pr + $urandom_range(1, (rc - pr < 32'd20) ? rc - pr : 32'd20);
                    c = pc;
                end else begin
                    c = pc + $urandom_range(1, 50);
                    r = any_index(rc);
                end
            end
            STYLE_DISTINCT: begin
                r = any_index(rc);
                c = any_index(cc);
                if (!fresh && r == pr && c == pc) begin
                    if (rc > 32'd1)
                        r = (r == 32'd1) ? 32'd2 : 32'd1;
                    else
                        c = (c == 32'd1) ? 32'd2 : 32'd1;
                end
            end
            default: begin
                if (!fresh && $urandom_range(0, 5) == 0 && pr <= rc && pc <= cc) begin
                    r = pr;
                    c = pc;
                end else begin
                    r = any_index(rc);
                    c = any_index(cc);
                end
            end
        endcase
    endfunction

    initial begin
        logic [31:0] r;
        logic [31:0] c;
        logic [31:0] rows_f;
        logic [31:0] cols_f;
        logic [63:0] entries_f;
        logic [7:0]  junk;
        bit          trail;
        int          variant;

        ledger = new();
        finish_case = finish_kind_e'($urandom_range(0, 8));
        case (finish_case)
            FINISH_CLEAN:    order_style = STYLE_ORDERED;
            FINISH_UNSORTED: order_style = STYLE_DISTINCT;
            default:         order_style = STYLE_FREE;
        endcase

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-column matrix, largest row, all four blanks, leading zero
        write_settings(32'hFFFF_FFFF, 32'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_text("1 1 1\n");
        send_text("4294967295\t1");
        send_item(CH_CR, 1'b0);
        send_text("01\n");

        // Random body in segments: new bounds every other segment, pacing rotates
        for (int seg = 0; seg < 8; seg++) begin
            drain_results();
            case (seg)
                0: write_settings(32'd1, 32'hFFFF_FFFF, 64'd0);
                2: write_settings($urandom_range(2, 32'hFFFF_FFFF), 32'hFFFF_FFFF,
                                  {$urandom, $urandom});
                4: write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
                6: write_settings($urandom_range(1, 100), 32'd1000000,
                                  64'hFFFF_FFFF_FFFF_FFFF);
                default: ;
            endcase
            case (pace_e'(seg % 4))
                PACE_STEADY:          begin idle_pct = 0;  stall_pct = 0;  end
                PACE_SENDER_GAPS:     begin idle_pct = 47; stall_pct = 0;  end
                PACE_RECEIVER_STALLS: begin idle_pct = 0;  stall_pct = 47; end
                default:              begin idle_pct = 7;  stall_pct = 7;  end
            endcase
            // Let the output back up until the input stalls
            if (seg == 4)
                hold_left = 300;
            while (items_sent < 25 + (seg + 1) * 135) begin
                pick_coordinate(r, c);
                send_triplet({32'd0, r}, {32'd0, c}, rand_value(), 1'b1);
            end
        end

        // Close the stream in the way drawn for this run
        drain_results();
        rows_f    = 32'hFFFF_FFFF;
        cols_f    = 32'hFFFF_FFFF;
        entries_f = {$urandom, $urandom};
        variant   = $urandom_range(0, 3);
        trail     = 1'($urandom_range(0, 1));
        case (finish_case)
            FINISH_CLEAN, FINISH_UNSORTED, FINISH_DUPLICATE:
                entries_f = ledger.entry_count + 64'd1;
            FINISH_MISMATCH:
                entries_f = (ledger.entry_count + 64'd1) ^ (64'd1 << $urandom_range(0, 63));
            FINISH_RANGE:
                if (variant == 3) begin
                    if ($urandom_range(0, 1))
                        rows_f = 32'd0;
                    else
                        cols_f = 32'd0;
                end
            default: ;
        endcase
        write_settings(rows_f, cols_f, entries_f);

        case (finish_case)
            FINISH_CLEAN:
                send_triplet({32'd0, any_index(rows_f)}, {32'd0, cols_f}, rand_value(), trail);
            FINISH_UNSORTED:
                if (ledger.last_row == 32'd1 && ledger.last_column == 32'd1)
                    send_triplet(64'd2, 64'd1, rand_value(), trail);
                else
                    send_triplet(64'd1, 64'd1, rand_value(), trail);
            FINISH_DUPLICATE:
                send_triplet({32'd0, ledger.last_row}, {32'd0, ledger.last_column},
                             rand_value(), trail);
            FINISH_MISMATCH: begin
                pick_coordinate(r, c);
                send_triplet({32'd0, r}, {32'd0, c}, rand_value(), trail);
            end
            FINISH_INCOMPLETE: begin
                send_number(rand_value());
                if ($urandom_range(0, 1)) begin
                    send_gap();
                    send_number(rand_value());
                end
                if (trail)
                    send_gap();
            end
            FINISH_ZERO_VALUE: begin
                pick_coordinate(r, c);
                send_triplet({32'd0, r}, {32'd0, c}, 64'd0, trail);
            end
            FINISH_RANGE:
                case (variant)
                    0:       send_triplet(64'd0, {32'd0, any_index(cols_f)}, rand_value(),
                                          trail);
                    1:       send_triplet({32'd0, rows_f} + 64'd1, {32'd0, any_index(cols_f)},
                                          rand_value(), trail);
                    2:       send_triplet({32'd0, any_index(rows_f)}, {32'd0, cols_f} + 64'd1,
                                          rand_value(), trail);
                    default: send_triplet(64'd1, 64'd1, rand_value(), trail);
                endcase
            FINISH_OVERFLOW: begin
                repeat (variant % 3) begin
                    send_number({32'd0, any_index(32'hFFFF_FFFF)});
                    send_gap();
                end
                // One more digit of six or above takes the number past 2^64-1
                send_number(64'd1844674407370955161);
                send_item(CH_ZERO + 8'($urandom_range(6, 9)), 1'b0);
            end
            default: begin
                repeat (variant % 3) begin
                    send_number({32'd0, any_index(32'hFFFF_FFFF)});
                    send_gap();
                end
                if (trail)
                    send_number(rand_value());
                do
                    junk = 8'($urandom_range(0, 255));
                while ((junk >= CH_ZERO && junk <= CH_NINE) || is_blank(junk));
                send_item(junk, 1'b0);
            end
        endcase
        send_item(8'($urandom_range(0, 255)), 1'b1);

        // The parser is halted now: any byte and end flag must be ignored
        idle_pct  = 7;
        stall_pct = 7;
        repeat (48) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        in_valid <= 1'b0;
        while (ledger.pending_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (ledger.fail_count == 0 && ledger.pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
